>>> hdl/lps_pkg.sv
`timescale 1ns / 1ps

package lps_pkg;

	// frame store geometry
	localparam int STORE_SIZE = 1024;
	localparam int ADDR_W     = 10;
	localparam int PAGE_W     = 3;
	localparam int HALVES_W   = 2;

	// defaults for top-level parameters
	localparam int DEF_COLUMNS        = 128;
	localparam int DEF_PAGES_PER_HALF = 4;
	localparam int DEF_FULL_PASSES    = 2;

	// slot layout within one page
	localparam int CMD_SLOTS = 3;
	localparam int PAD_SLOTS = 2;
	localparam int SLOT_COL_LOW  = 0;
	localparam int SLOT_COL_HIGH = 1;
	localparam int SLOT_PAGE     = 2;

	// command bytes
	localparam logic [7:0] CMD_COL_LOW    = 8'h00;
	localparam logic [7:0] CMD_COL_HIGH   = 8'h10;
	localparam logic [7:0] CMD_PAGE       = 8'hB0;
	localparam logic [7:0] CMD_DISPLAY_ON = 8'hAF;

	// request modes
	localparam logic [1:0] MODE_WRITE = 2'd0;
	localparam logic [1:0] MODE_FAST  = 2'd1;
	localparam logic [1:0] MODE_FULL  = 2'd2;
	localparam logic [1:0] MODE_TICK  = 2'd3;

	typedef struct packed {
		logic [1:0]        mode;
		logic [ADDR_W-1:0] address;
		logic [7:0]        data;
	} lps_req_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       is_data;
		logic       burst_end;
		logic       refresh_done;
	} lps_res_t;

	// controller -> datapath
	typedef struct packed {
		logic              clear_we;
		logic              write_we;
		logic              emit;
		logic              use_mem;
		logic [ADDR_W-1:0] rd_addr;
		logic [7:0]        byte_val;
		logic              is_data;
		logic              burst_end;
		logic              done;
	} lps_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic clear_last;
	} lps_stat_t;

endpackage

>>> hdl/lps_datapath.sv
`timescale 1ns / 1ps

module lps_datapath
	import lps_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  lps_req_t  request,
	input  lps_cmd_t  cmd,
	output lps_stat_t stat,
	output logic      strobe,
	output lps_res_t  result
);

	logic [7:0]        mem [STORE_SIZE];
	logic [ADDR_W-1:0] clr_q;
	logic              we;
	logic [ADDR_W-1:0] waddr;
	logic [7:0]        wdata;

	logic [7:0] rdata_s1;
	logic [7:0] byte_s1;
	logic       use_mem_s1;
	logic       is_data_s1;
	logic       end_s1;
	logic       done_s1;
	logic       valid_s1;

	assign we    = cmd.clear_we | cmd.write_we;
	assign waddr = cmd.clear_we ? clr_q : request.address;
	assign wdata = cmd.clear_we ? 8'h00 : request.data;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_s1 <= mem[cmd.rd_addr];
	end

	// clearing sweep address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clear_we) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	assign stat.clear_last = (clr_q == {ADDR_W{1'b1}});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= cmd.emit;
		end
	end

	always_ff @(posedge clk) begin
		byte_s1    <= cmd.byte_val;
		use_mem_s1 <= cmd.use_mem;
		is_data_s1 <= cmd.is_data;
		end_s1     <= cmd.burst_end;
		done_s1    <= cmd.done;
	end

	assign strobe              = valid_s1;
	assign result.out_byte     = use_mem_s1 ? rdata_s1 : byte_s1;
	assign result.is_data      = is_data_s1;
	assign result.burst_end    = end_s1;
	assign result.refresh_done = done_s1;

endmodule

>>> hdl/lps_ctrl.sv
`timescale 1ns / 1ps

module lps_ctrl
	import lps_pkg::*;
#(
	parameter int COLUMNS        = DEF_COLUMNS,
	parameter int PAGES_PER_HALF = DEF_PAGES_PER_HALF,
	parameter int FULL_PASSES    = DEF_FULL_PASSES
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic [1:0] mode,
	input  lps_stat_t  stat,
	output logic       busy,
	output lps_cmd_t   cmd
);

	localparam int SLOT_W  = $clog2(COLUMNS + CMD_SLOTS + 2 * PAD_SLOTS);
	localparam int PCNT_W  = (PAGES_PER_HALF > 1) ? $clog2(PAGES_PER_HALF) : 1;
	localparam int DATA_FIRST = CMD_SLOTS + PAD_SLOTS;
	localparam int DATA_END   = DATA_FIRST + COLUMNS;
	localparam int LAST_SLOT  = DATA_END + PAD_SLOTS - 1;

	localparam logic [PCNT_W-1:0]   LAST_PAGE = PCNT_W'(PAGES_PER_HALF - 1);
	localparam logic [HALVES_W-1:0] FULL_HALVES = HALVES_W'(FULL_PASSES);

	localparam logic ST_CLEAR = 1'b0;
	localparam logic ST_READY = 1'b1;

	logic                state_q, state_d;
	logic                run_q, run_d;
	logic                dop_q, dop_d;
	logic                half_q, half_d;
	logic [HALVES_W-1:0] halves_q, halves_d;
	logic [PCNT_W-1:0]   page_q, page_d;
	logic [SLOT_W-1:0]   slot_q, slot_d;

	logic              accept;
	logic [PAGE_W-1:0] page_num;
	logic              last_slot;
	logic              last_page;
	logic              last_half;

	assign busy   = (state_q == ST_CLEAR);
	assign accept = start && !busy;

	assign page_num  = half_q ? PAGE_W'(PAGES_PER_HALF + int'(page_q)) : PAGE_W'(page_q);
	assign last_slot = (slot_q == SLOT_W'(LAST_SLOT));
	assign last_page = (page_q == LAST_PAGE);
	assign last_half = (halves_q <= HALVES_W'(1));

	always_comb begin
		state_d  = state_q;
		run_d    = run_q;
		dop_d    = dop_q;
		half_d   = half_q;
		halves_d = halves_q;
		page_d   = page_q;
		slot_d   = slot_q;

		cmd          = '0;
		cmd.rd_addr  = ADDR_W'(int'(page_num) * COLUMNS + int'(slot_q) - DATA_FIRST);

		if (state_q == ST_CLEAR) begin
			cmd.clear_we = 1'b1;
			if (stat.clear_last) begin
				state_d = ST_READY;
			end
		end else if (accept) begin
			unique case (mode)
				MODE_WRITE: begin
					cmd.write_we = 1'b1;
				end
				MODE_FAST, MODE_FULL: begin
					if (!run_q) begin
						run_d    = 1'b1;
						dop_d    = (mode == MODE_FULL);
						halves_d = (mode == MODE_FULL) ? FULL_HALVES : HALVES_W'(1);
						page_d   = '0;
						slot_d   = '0;
					end
				end
				MODE_TICK: begin
					if (run_q) begin
						cmd.emit = 1'b1;
						if (dop_q) begin
							dop_d         = 1'b0;
							cmd.byte_val  = CMD_DISPLAY_ON;
							cmd.burst_end = 1'b1;
						end else begin
							priority if (slot_q == SLOT_W'(SLOT_COL_LOW)) begin
								cmd.byte_val  = CMD_COL_LOW;
								cmd.burst_end = 1'b1;
							end else if (slot_q == SLOT_W'(SLOT_COL_HIGH)) begin
								cmd.byte_val  = CMD_COL_HIGH;
								cmd.burst_end = 1'b1;
							end else if (slot_q == SLOT_W'(SLOT_PAGE)) begin
								cmd.byte_val  = CMD_PAGE | {{(8 - PAGE_W){1'b0}}, page_num};
								cmd.burst_end = 1'b1;
							end else if (slot_q < SLOT_W'(DATA_FIRST)) begin
								cmd.is_data = 1'b1;
							end else if (slot_q < SLOT_W'(DATA_END)) begin
								cmd.is_data = 1'b1;
								cmd.use_mem = 1'b1;
							end else begin
								cmd.is_data   = 1'b1;
								cmd.burst_end = last_slot;
								cmd.done      = last_slot && last_page && last_half;
							end

							if (last_slot) begin
								slot_d = '0;
								if (last_page) begin
									page_d = '0;
									half_d = ~half_q;
									if (last_half) begin
										halves_d = '0;
										run_d    = 1'b0;
									end else begin
										halves_d = halves_q - 1'b1;
									end
								end else begin
									page_d = page_q + 1'b1;
								end
							end else begin
								slot_d = slot_q + 1'b1;
							end
						end
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_CLEAR;
			run_q    <= 1'b0;
			dop_q    <= 1'b0;
			half_q   <= 1'b0;
			halves_q <= '0;
			page_q   <= '0;
			slot_q   <= '0;
		end else begin
			state_q  <= state_d;
			run_q    <= run_d;
			dop_q    <= dop_d;
			half_q   <= half_d;
			halves_q <= halves_d;
			page_q   <= page_d;
			slot_q   <= slot_d;
		end
	end

endmodule

>>> hdl/lcd_page_refresh_sequencer.sv
`timescale 1ns / 1ps
// channel   handshake                payload
// request   start high, busy low     request (mode, address, data)
// result    strobe, one cycle        result (out_byte, is_data, burst_end, refresh_done)
//
// One request per clock while busy is low. A tick that emits a byte shows its
// result on the cycle after acceptance; the frame store read is registered in
// that step. After reset the frame store is swept to zero, one byte per cycle,
// all 1024 bytes: busy stays high until the sweep ends; no request is taken.
// The receiver cannot stall; each strobe lasts exactly one cycle.

module lcd_page_refresh_sequencer
	import lps_pkg::*;
#(
	parameter int COLUMNS        = DEF_COLUMNS,
	parameter int PAGES_PER_HALF = DEF_PAGES_PER_HALF,
	parameter int FULL_PASSES    = DEF_FULL_PASSES
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	input  lps_req_t request,
	output logic     strobe,
	output lps_res_t result
);

	lps_cmd_t  cmd;
	lps_stat_t stat;

	lps_ctrl #(
		.COLUMNS       (COLUMNS),
		.PAGES_PER_HALF(PAGES_PER_HALF),
		.FULL_PASSES   (FULL_PASSES)
	) u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.mode  (request.mode),
		.stat  (stat),
		.busy  (busy),
		.cmd   (cmd)
	);

	lps_datapath u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.request(request),
		.cmd    (cmd),
		.stat   (stat),
		.strobe (strobe),
		.result (result)
	);

endmodule
